// File: hdl/cbts_pkg.sv
package cbts_pkg;

    localparam int unsigned CLK_W  = 27;
    localparam int unsigned RATE_W = 20;
    localparam int unsigned WORD_W = 15;
    localparam int unsigned DIV_W  = 4;
    localparam int unsigned QIDX_W = 5;
    localparam int unsigned REST_W = 4;
    localparam int unsigned QD_W   = 10;
    localparam int unsigned PROD_W = 14;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [CLK_W-1:0]  CLK_RESET      = 27'd48000000;
    localparam logic [DIV_W-1:0]  DIV_LAST       = 4'd15;
    localparam logic [QIDX_W-1:0] QIDX_LAST      = 5'd31;
    localparam logic [REST_W-1:0] REST_LAST      = 4'd14;
    localparam logic [CNT_W-1:0]  DIV_STEP_LAST  = 5'd26;
    localparam logic [ADDR_W-1:0] ADDR_CLK_HZ    = 3'd0;

    typedef struct packed {
        logic load;
        logic div_step;
        logic srch_init;
        logic srch_step;
        logic hold;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic match;
        logic last;
    } t_dp_sts;

    function automatic logic [WORD_W-1:0] pack_word(input logic [QIDX_W-1:0] qidx,
                                                    input logic [REST_W-1:0] rest);
        logic [2:0] seg1;
        logic [REST_W-1:0] seg2;
        logic [1:0] sjw;
        seg1 = rest[3:1];
        seg2 = rest - {1'b0, seg1};
        sjw  = (seg1 > 3'd3) ? 2'd3 : seg1[1:0];
        return {seg2[2:0], 1'b0, seg1, sjw, 1'b0, qidx};
    endfunction

endpackage

// File: hdl/cbts_dp.sv
module cbts_dp (
    input  logic                        i_clk,
    input  logic [cbts_pkg::CLK_W-1:0]  i_clk_hz,
    input  logic [cbts_pkg::RATE_W-1:0] i_bit_rate,
    input  cbts_pkg::t_dp_cmd           i_cmd,
    output cbts_pkg::t_dp_sts           o_sts,
    output logic                        o_found,
    output logic [cbts_pkg::DIV_W-1:0]  o_prescaler_div,
    output logic [cbts_pkg::WORD_W-1:0] o_timing_word
);
    import cbts_pkg::*;

    logic [RATE_W-1:0] r_dvsr;
    logic [RATE_W-1:0] r_rem;
    logic [CLK_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_d;
    logic [QIDX_W-1:0] r_q;
    logic [REST_W-1:0] r_rest;
    logic [QD_W-1:0]   r_qd;
    logic [PROD_W-1:0] r_p;
    logic              r_hit;
    logic [DIV_W-1:0]  r_hit_div;
    logic [WORD_W-1:0] r_hit_word;
    logic              r_found;
    logic [DIV_W-1:0]  r_pdiv;
    logic [WORD_W-1:0] r_word;

    logic [RATE_W:0]   rem_sh;
    logic [RATE_W:0]   rem_diff;
    logic              ge;
    logic [QD_W-1:0]   n_qd;
    logic [QD_W-1:0]   d_plus;
    logic [PROD_W-1:0] n_p;

    assign rem_sh   = {r_rem, r_quo[CLK_W-1]};
    assign ge       = rem_sh >= {1'b0, r_dvsr};
    assign rem_diff = rem_sh - {1'b0, r_dvsr};

    assign d_plus = {{(QD_W-DIV_W){1'b0}}, r_d} + QD_W'(1);

    always_comb begin
        n_qd = r_qd;
        n_p  = r_p + {{(PROD_W-QD_W){1'b0}}, r_qd};
        if (r_rest == REST_LAST) begin
            if (r_q != QIDX_LAST) begin
                n_qd = r_qd + d_plus;
            end else begin
                n_qd = d_plus + QD_W'(1);
            end
            n_p = {{(PROD_W-QD_W){1'b0}}, n_qd} + {{(PROD_W-QD_W-1){1'b0}}, n_qd, 1'b0};
        end
    end

    assign o_sts.match = {{(CLK_W-PROD_W){1'b0}}, r_p} == r_quo;
    assign o_sts.last  = (r_d == DIV_LAST) && (r_q == QIDX_LAST) && (r_rest == REST_LAST);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dvsr <= i_bit_rate;
            r_rem  <= '0;
            r_quo  <= i_clk_hz;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? rem_diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
            r_quo <= {r_quo[CLK_W-2:0], ge};
        end

        if (i_cmd.srch_init) begin
            r_d    <= '0;
            r_q    <= '0;
            r_rest <= '0;
            r_qd   <= QD_W'(1);
            r_p    <= PROD_W'(3);
        end else if (i_cmd.srch_step) begin
            r_qd <= n_qd;
            r_p  <= n_p;
            if (r_rest != REST_LAST) begin
                r_rest <= r_rest + REST_W'(1);
            end else begin
                r_rest <= '0;
                r_q    <= r_q + QIDX_W'(1);
                if (r_q == QIDX_LAST) begin
                    r_d <= r_d + DIV_W'(1);
                end
            end
        end

        if (i_cmd.hold) begin
            r_hit      <= o_sts.match;
            r_hit_div  <= o_sts.match ? r_d : '0;
            r_hit_word <= o_sts.match ? pack_word(r_q, r_rest) : '0;
        end

        if (i_cmd.out_load) begin
            r_found <= r_hit;
            r_pdiv  <= r_hit_div;
            r_word  <= r_hit_word;
        end
    end

    assign o_found         = r_found;
    assign o_prescaler_div = r_pdiv;
    assign o_timing_word   = r_word;

endmodule

// File: hdl/cbts_ctrl.sv
module cbts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  cbts_pkg::t_dp_sts i_sts,
    output cbts_pkg::t_dp_cmd o_cmd
);
    import cbts_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    t_dp_cmd          cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_cnt    = '0;
                    n_state  = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + CNT_W'(1);
                if (r_cnt == DIV_STEP_LAST) begin
                    cmd.srch_init = 1'b1;
                    n_state       = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_sts.match || i_sts.last) begin
                    cmd.hold = 1'b1;
                    n_state  = ST_FINISH;
                end else begin
                    cmd.srch_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// File: hdl/can_bit_timing_search_top.sv
// each item passes through the division, a search over n combinations and a finish step,
// n = combinations tried (1 to 7680, divider 0..15 x quanta 1..32 x segments 3..17),
// before the result is valid
// one item at a time: the next item is accepted only once the last one is finished, later if a result waits
// a finished result waits in the output register while the next item is accepted
// reset: synchronous active low, clears control state and sets module clock to 48 MHz
module can_bit_timing_search_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cbts_pkg::ADDR_W-1:0] paddr,
    input  logic [cbts_pkg::DATA_W-1:0] pwdata,
    output logic [cbts_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [cbts_pkg::RATE_W-1:0] i_bit_rate,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_found,
    output logic [cbts_pkg::DIV_W-1:0]  o_prescaler_div,
    output logic [cbts_pkg::WORD_W-1:0] o_timing_word
);
    import cbts_pkg::*;

    logic [CLK_W-1:0] r_clk_hz;
    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic             reg_sel;

    assign reg_sel = (paddr == ADDR_CLK_HZ);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(DATA_W-CLK_W){1'b0}}, r_clk_hz} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= CLK_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_clk_hz <= pwdata[CLK_W-1:0];
        end
    end

    cbts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cbts_dp u_dp (
        .i_clk           (i_clk),
        .i_clk_hz        (r_clk_hz),
        .i_bit_rate      (i_bit_rate),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_found         (o_found),
        .o_prescaler_div (o_prescaler_div),
        .o_timing_word   (o_timing_word)
    );

endmodule

// File: hdl/cbts_chk.sv
module cbts_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_found,
    input logic [cbts_pkg::DIV_W-1:0]  o_prescaler_div,
    input logic [cbts_pkg::WORD_W-1:0] o_timing_word
);
    import cbts_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found)
            && $stable(o_prescaler_div) && $stable(o_timing_word))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_prescaler_div == '0 && o_timing_word == '0)
        else $error("not-found result has nonzero fields");

    a_seg_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |->
            ({1'b0, o_timing_word[14:12]} == o_timing_word[11:8]
             || {1'b0, o_timing_word[14:12]} == o_timing_word[11:8] + 4'd1)
            && (o_timing_word[11:8] > 4'd3 ? o_timing_word[7:6] == 2'd3
                : {2'b00, o_timing_word[7:6]} == o_timing_word[11:8]))
        else $error("inconsistent segment split");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind can_bit_timing_search_top cbts_chk u_cbts_chk (.*);

// File: bench/tb_can_bit_timing_search_top.sv
`timescale 1ns / 100ps

typedef struct {
    logic [cbts_pkg::RATE_W-1:0] rate;
    logic                        found;
    logic [cbts_pkg::DIV_W-1:0]  div;
    logic [cbts_pkg::WORD_W-1:0] word;
} t_timing;

class timing_scoreboard;
    logic [cbts_pkg::CLK_W-1:0] clk_hz;
    t_timing pending_q[$];

    function new();
        clk_hz = cbts_pkg::CLK_RESET;
    endfunction

    function void set_clock(logic [cbts_pkg::CLK_W-1:0] hz);
        clk_hz = hz;
    endfunction

    // first divider / quanta / segments combination whose product equals clocks per bit
    function t_timing search_timing(logic [cbts_pkg::RATE_W-1:0] rate);
        t_timing r;
        int unsigned cpb;
        int unsigned rest;
        int unsigned seg1;
        int unsigned seg2;
        int unsigned sjw;
        bit hit;
        r.rate = rate;
        r.found = 1'b0;
        r.div = '0;
        r.word = '0;
        hit = 1'b0;
        if (rate == 0) begin
            return r;
        end
        cpb = clk_hz / rate;
        for (int d = 0; d <= 15 && !hit; d++) begin
            for (int q = 1; q <= 32 && !hit; q++) begin
                for (int s = 3; s <= 17 && !hit; s++) begin
                    if (cpb == s * q * (d + 1)) begin
                        hit = 1'b1;
                        rest = s - 3;
                        seg1 = rest / 2;
                        seg2 = rest - seg1;
                        sjw = (seg1 > 3) ? 3 : seg1;
                        r.found = 1'b1;
                        r.div = d[3:0];
                        r.word = 15'(((q - 1) & 'h3F) | ((sjw & 'h3) << 6)
                                     | ((seg1 & 'hF) << 8) | ((seg2 & 'h7) << 12));
                    end
                end
            end
        end
        return r;
    endfunction

    function void note_rate(logic [cbts_pkg::RATE_W-1:0] rate);
        pending_q.push_back(search_timing(rate));
    endfunction

    function string check_result(logic f, logic [cbts_pkg::DIV_W-1:0] d,
                                 logic [cbts_pkg::WORD_W-1:0] w);
        t_timing e;
        if (pending_q.size() == 0) begin
            return $sformatf("unexpected result found=%0b div=%0d word=%h", f, d, w);
        end
        e = pending_q.pop_front();
        if (f !== e.found || d !== e.div || w !== e.word) begin
            return $sformatf("rate %0d clk %0d: got found=%0b div=%0d word=%h, exp %0b/%0d/%h",
                             e.rate, clk_hz, f, d, w, e.found, e.div, e.word);
        end
        return "";
    endfunction

    function int count();
        return pending_q.size();
    endfunction
endclass

module tb_can_bit_timing_search_top;

    localparam logic [cbts_pkg::ADDR_W-1:0] ADDR_SPARE = 3'd4;
    localparam int LONG_STALL = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [cbts_pkg::ADDR_W-1:0] paddr = '0;
    logic [cbts_pkg::DATA_W-1:0] pwdata = '0;
    logic [cbts_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [cbts_pkg::RATE_W-1:0] i_bit_rate = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_found;
    logic [cbts_pkg::DIV_W-1:0] o_prescaler_div;
    logic [cbts_pkg::WORD_W-1:0] o_timing_word;

    timing_scoreboard sb = new();

    int n_errors = 0;
    int n_sent = 0;
    int n_found = 0;
    int n_missed = 0;
    int n_clocks = 0;
    int n_holds = 0;
    int stall_req = 0;
    int stall_ack = 0;
    int stall_left = 0;
    int mode_left = 0;
    int ready_mode = 0;
    int rx_cyc = 0;
    string chk_msg;

    can_bit_timing_search_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_bit_rate      (i_bit_rate),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_prescaler_div (o_prescaler_div),
        .o_timing_word   (o_timing_word)
    );

    always #5 i_clk = ~i_clk;

    task automatic report(string msg);
        n_errors++;
        if (n_errors <= 100) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_ack != stall_req) begin
            stall_ack <= stall_req;
            stall_left <= LONG_STALL;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left <= $urandom_range(20, 200);
                ready_mode <= $urandom_range(0, 2);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    i_out_ready <= (rx_cyc % 7 < 2);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (o_found) begin
                n_found++;
            end else begin
                n_missed++;
            end
            chk_msg = sb.check_result(o_found, o_prescaler_div, o_timing_word);
            if (chk_msg != "") begin
                report(chk_msg);
            end
        end
    end

    task automatic apb_write(logic [cbts_pkg::ADDR_W-1:0] addr, logic [cbts_pkg::DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(logic [cbts_pkg::ADDR_W-1:0] addr,
                            output logic [cbts_pkg::DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_clock_reg();
        logic [cbts_pkg::DATA_W-1:0] rd;
        apb_read(cbts_pkg::ADDR_CLK_HZ, rd);
        if (rd !== {{(cbts_pkg::DATA_W - cbts_pkg::CLK_W){1'b0}}, sb.clk_hz}) begin
            report($sformatf("clock register reads %0d, expected %0d", rd, sb.clk_hz));
        end
    endtask

    task automatic set_clock_reg(logic [cbts_pkg::DATA_W-1:0] value);
        apb_write(cbts_pkg::ADDR_CLK_HZ, value);
        sb.set_clock(value[cbts_pkg::CLK_W-1:0]);
        n_clocks++;
        check_clock_reg();
    endtask

    task automatic send_rate(logic [cbts_pkg::RATE_W-1:0] rate);
        i_in_valid <= 1'b1;
        i_bit_rate <= rate;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_rate(rate);
        n_sent++;
    endtask

    task automatic idle(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.count() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly rates that divide the clock into a reachable product, some noise
    function automatic logic [cbts_pkg::RATE_W-1:0] random_rate(logic [cbts_pkg::CLK_W-1:0] hz,
                                                                bit quick);
        int unsigned p;
        int unsigned r;
        int unsigned d;
        int unsigned q;
        int unsigned s;
        r = 1;
        if (!quick && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: return 20'($urandom);
                1: return 20'($urandom_range(1, 1000000));
                default: return 20'($urandom_range(0, 64));
            endcase
        end
        for (int t = 0; t < 20; t++) begin
            if (quick) begin
                d = 0;
                q = $urandom_range(3, 6);
            end else begin
                d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
                q = $urandom_range(1, 32);
            end
            s = $urandom_range(3, 17);
            p = s * q * (d + 1);
            r = hz / p;
            if (hz % p == 0 && r >= 1 && r <= 20'hFFFFF) begin
                return 20'(r);
            end
        end
        if (r == 0) begin
            r = 1;
        end else if (r > 20'hFFFFF) begin
            r = 20'hFFFFF;
        end
        return 20'(r);
    endfunction

    task automatic run_phase(logic [cbts_pkg::CLK_W-1:0] hz, int n, bit hold);
        int left;
        int burst;
        set_clock_reg(32'(hz));
        left = n;
        if (hold) begin
            // receiver holds off while fast transfers keep coming
            stall_req <= stall_req + 1;
            n_holds++;
            repeat (8) send_rate(random_rate(hz, 1'b1));
            left -= 8;
        end
        while (left > 0) begin
            burst = $urandom_range(1, 8);
            if (burst > left) begin
                burst = left;
            end
            repeat (burst) send_rate(random_rate(hz, 1'b0));
            left -= burst;
            if (left > 0 && $urandom_range(0, 3) != 0) begin
                idle($urandom_range(1, 15));
            end
        end
        drain();
    endtask

    initial begin
        #40_000_000;
        $display("** can_bit_timing_search_top: FAILED **");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_clock_reg();

        send_rate(20'd0);
        send_rate(20'd1);
        send_rate(20'hFFFFF);
        send_rate(20'd1000000);
        send_rate(20'd500000);
        send_rate(20'd125000);
        send_rate(20'h55555);
        send_rate(20'hAAAAA);
        send_rate(20'd3000);
        drain();

        // last combination of the search, then the largest segment count with divider 0 and one quantum
        set_clock_reg(32'd8704000);
        send_rate(20'd1000);
        send_rate(20'd512000);
        drain();

        set_clock_reg(32'd0);
        send_rate(20'd1000);
        send_rate(20'd1);
        drain();

        // first combination of the search, then clocks per bit below the smallest product
        set_clock_reg(32'd3000);
        send_rate(20'd1000);
        send_rate(20'd3000);
        drain();

        // write to an unmapped register must leave the clock alone
        apb_write(ADDR_SPARE, 32'h0123_4567);
        check_clock_reg();
        send_rate(20'd1000);
        drain();

        set_clock_reg(32'hFFFF_FFFF);
        send_rate(20'hFFFFF);
        send_rate(20'd1);
        drain();

        set_clock_reg(32'd1);
        send_rate(20'd1);
        drain();

        set_clock_reg(32'd100000000);
        send_rate(20'd1000000);
        drain();

        run_phase(27'd40000000, 25, 1'b1);
        run_phase(27'd100000000, 25, 1'b0);
        run_phase(27'($urandom_range(1000000, 100000000)), 25, 1'b0);
        run_phase(27'd24000000, 25, 1'b0);

        repeat (50) @(posedge i_clk);
        $display("coverage: %0d bit rate transfers over %0d clock settings, %0d long hold-off(s)",
                 n_sent, n_clocks, n_holds);
        $display("coverage: %0d timings found, %0d not found", n_found, n_missed);
        if (n_errors == 0) begin
            $display("** can_bit_timing_search_top: PASSED **");
        end else begin
            $display("** can_bit_timing_search_top: FAILED **");
        end
        $finish;
    end

endmodule
